[sv/assert_macros.svh]
// Assertion macros used by the port-level checker of the divider.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of clk while rst_n is high.
`define SIDV_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks prop at every rising edge of clk, reset included.
`define SIDV_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/sidv_pkg.sv]
// Shared types for the signed divider pipeline.
// No dependencies.
package sidv_pkg;

  // Control bits that travel with each item through the cell chain.
  typedef struct packed {
    logic valid;
    logic neg;
    logic dbz;
  } sidv_ctl_t;

endpackage

[sv/signed_integer_divider_core.sv]
// An accepted item passes through the input register, one cell per quotient bit and the output register.
// Throughput: one item per cycle while the output is not stalled; the chain length sets latency.
// A stalled output holds the whole chain; in_ready_o follows the output register.
// Reset clears all valid bits asynchronously; data registers are not reset.
// Depends on sidv_pkg and sidv_cell.
module signed_integer_divider_core #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] dividend_i,
  input  logic signed [DATA_WIDTH-1:0] divisor_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] quotient_o,
  output logic                         overflow_o,
  output logic                         divide_by_zero_o
);
  import sidv_pkg::*;

  localparam int unsigned W = DATA_WIDTH;
  localparam logic [W-1:0] IntMax = {1'b0, {(W-1){1'b1}}};

  logic         adv;
  logic [W-1:0] a_u, b_u, ma_d, mb_d;
  sidv_ctl_t    pr_ctl_q, pr_ctl_d;
  logic [W-1:0] pr_ma_q, pr_mb_q;

  sidv_ctl_t    ctl_s [0:W];
  logic [W-1:0] rem_s [0:W];
  logic [W-1:0] aq_s  [0:W];
  logic [W-1:0] mb_s  [0:W];

  logic         out_valid_q;
  logic [W-1:0] quotient_q, quotient_d;
  logic         ovf_q, ovf_d;
  logic         dbz_q;
  sidv_ctl_t    fin;
  logic [W-1:0] mq;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Input conditioning: magnitudes, result sign and zero-divisor flag.
  always_comb begin
    a_u            = $unsigned(dividend_i);
    b_u            = $unsigned(divisor_i);
    ma_d           = a_u[W-1] ? (~a_u + 1'b1) : a_u;
    mb_d           = b_u[W-1] ? (~b_u + 1'b1) : b_u;
    pr_ctl_d.valid = in_valid_i;
    pr_ctl_d.neg   = a_u[W-1] ^ b_u[W-1];
    pr_ctl_d.dbz   = (b_u == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_ctl_q <= '0;
    end else if (adv) begin
      pr_ctl_q <= pr_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_ma_q <= ma_d;
      pr_mb_q <= mb_d;
    end
  end

  assign ctl_s[0] = pr_ctl_q;
  assign rem_s[0] = '0;
  assign aq_s[0]  = pr_ma_q;
  assign mb_s[0]  = pr_mb_q;

  for (genvar k = 0; k < W; k++) begin : g_cell
    sidv_cell #(.W(W)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctl_i  (ctl_s[k]),
      .rem_i  (rem_s[k]),
      .aq_i   (aq_s[k]),
      .mb_i   (mb_s[k]),
      .ctl_o  (ctl_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .aq_o   (aq_s[k+1]),
      .mb_o   (mb_s[k+1])
    );
  end

  // The magnitude quotient can exceed the largest positive value only for the most negative
  // dividend over one or minus one; only the positive result, over minus one, saturates.
  always_comb begin
    fin = ctl_s[W];
    mq  = aq_s[W];
    ovf_d = 1'b0;
    if (fin.dbz) begin
      quotient_d = '0;
    end else if (fin.neg) begin
      quotient_d = ~mq + 1'b1;
    end else if (mq[W-1]) begin
      quotient_d = IntMax;
      ovf_d      = 1'b1;
    end else begin
      quotient_d = mq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      quotient_q <= quotient_d;
      ovf_q      <= ovf_d;
      dbz_q      <= fin.dbz;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign quotient_o       = $signed(quotient_q);
  assign overflow_o       = ovf_q;
  assign divide_by_zero_o = dbz_q;

endmodule

[sv/sidv_cell.sv]
// One restoring division step with its stage register.
// Depends on sidv_pkg.
module sidv_cell #(
  parameter int unsigned W = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  sidv_pkg::sidv_ctl_t ctl_i,
  input  logic [W-1:0]       rem_i,
  input  logic [W-1:0]       aq_i,
  input  logic [W-1:0]       mb_i,
  output sidv_pkg::sidv_ctl_t ctl_o,
  output logic [W-1:0]       rem_o,
  output logic [W-1:0]       aq_o,
  output logic [W-1:0]       mb_o
);
  import sidv_pkg::*;

  sidv_ctl_t    ctl_q;
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] aq_q, aq_d;
  logic [W-1:0] mb_q;
  logic [W:0]   partial;
  logic [W+1:0] diff;
  logic         qbit;

  // The partial remainder is below twice the divisor, so one extra bit
  // plus a borrow bit covers the trial subtraction.
  always_comb begin
    partial = {rem_i, aq_i[W-1]};
    diff    = {1'b0, partial} - {2'b00, mb_i};
    qbit    = ~diff[W+1];
    rem_d   = qbit ? diff[W-1:0] : partial[W-1:0];
    aq_d    = {aq_i[W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      aq_q  <= aq_d;
      mb_q  <= mb_i;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign aq_o  = aq_q;
  assign mb_o  = mb_q;

endmodule

[sv/sidv_checker.sv]
// Port-level checks for the signed divider, bound to the top level.
// Depends on assert_macros.svh and signed_integer_divider_core.
`include "assert_macros.svh"

module sidv_checker #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] quotient_o,
  input logic                  overflow_o,
  input logic                  divide_by_zero_o
);

  localparam logic [DATA_WIDTH-1:0] IntMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // A result that is not taken stays on the port.
  `SIDV_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(quotient_o), "result changed while stalled")
  // A stalled output must also stall the input side.
  `SIDV_ASSERT(a_stall_in, clk_i, rst_ni, out_valid_o && !out_ready_i |-> !in_ready_o, "input taken during output stall")
  `SIDV_ASSERT(a_flags_excl, clk_i, rst_ni, out_valid_o |-> !(overflow_o && divide_by_zero_o), "both flags raised")
  `SIDV_ASSERT(a_dbz_zero, clk_i, rst_ni, out_valid_o && divide_by_zero_o |-> quotient_o == '0, "zero divisor gave nonzero quotient")
  `SIDV_ASSERT(a_ovf_sat, clk_i, rst_ni, out_valid_o && overflow_o |-> quotient_o == IntMax, "overflow did not saturate")

endmodule

bind signed_integer_divider_core sidv_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sidv_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .quotient_o       (quotient_o),
  .overflow_o       (overflow_o),
  .divide_by_zero_o (divide_by_zero_o)
);

[dv/sidv_div_checker.sv]
// Checker for the signed divider core: watches both item channels, predicts each
// quotient and its flags from the accepted operands, and compares them in order.
// Depends only on the port list of signed_integer_divider_core.
module sidv_div_checker #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [DATA_WIDTH-1:0] dividend_i,
  input  logic [DATA_WIDTH-1:0] divisor_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [DATA_WIDTH-1:0] quotient_i,
  input  logic                  overflow_i,
  input  logic                  divide_by_zero_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  typedef struct packed {
    logic [DATA_WIDTH-1:0] quotient;
    logic                  overflow;
    logic                  divide_by_zero;
  } div_result_t;

  div_result_t quotients_due[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  // Divides magnitudes and applies the sign afterwards, so the most negative
  // value needs no special path except when the quotient comes out positive.
  function automatic div_result_t trunc_quotient(input logic [DATA_WIDTH-1:0] num,
                                                 input logic [DATA_WIDTH-1:0] den);
    div_result_t           res;
    logic [DATA_WIDTH-1:0] mag_num;
    logic [DATA_WIDTH-1:0] mag_den;
    logic [DATA_WIDTH-1:0] mag_q;
    logic [DATA_WIDTH-1:0] max_pos;
    logic                  neg;
    res     = '0;
    max_pos = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    if (den == '0) begin
      res.divide_by_zero = 1'b1;
    end else begin
      neg     = num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
      mag_num = num[DATA_WIDTH-1] ? -num : num;
      mag_den = den[DATA_WIDTH-1] ? -den : den;
      mag_q   = mag_num / mag_den;
      if (neg) begin
        res.quotient = -mag_q;
      end else if (mag_q > max_pos) begin
        res.quotient = max_pos;
        res.overflow = 1'b1;
      end else begin
        res.quotient = mag_q;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    div_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        quotients_due.push_back(trunc_quotient(dividend_i, divisor_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (quotients_due.size() == 0) begin
          report_mismatch($sformatf("result with no item pending: quotient %0d",
                                    $signed(quotient_i)));
        end else begin
          want = quotients_due.pop_front();
          checked_o++;
          if (quotient_i !== want.quotient) begin
            report_mismatch($sformatf("quotient %0d, expected %0d",
                                      $signed(quotient_i), $signed(want.quotient)));
          end
          if (overflow_i !== want.overflow) begin
            report_mismatch($sformatf("overflow %b, expected %b",
                                      overflow_i, want.overflow));
          end
          if (divide_by_zero_i !== want.divide_by_zero) begin
            report_mismatch($sformatf("divide_by_zero %b, expected %b",
                                      divide_by_zero_i, want.divide_by_zero));
          end
        end
      end
      pending_o = quotients_due.size();
    end
  end

endmodule

[dv/signed_integer_divider_core_tb.sv]
// Top of the divider testbench: clock, reset, operand and result handshakes, watchdog.
// Depends on signed_integer_divider_core and the checker in sidv_div_checker.sv.
module signed_integer_divider_core_tb;

  localparam int unsigned DATA_WIDTH      = 32;
  localparam int          LATENCY         = DATA_WIDTH + 2;
  localparam int          HOLD_OFF_CYCLES = 150;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          RANDOM_ITEMS    = 450;
  localparam logic [DATA_WIDTH-1:0] INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] INT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  out_ready      = 1'b0;
  logic [DATA_WIDTH-1:0] dividend       = '0;
  logic [DATA_WIDTH-1:0] divisor        = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic [DATA_WIDTH-1:0] quotient;
  logic                  overflow;
  logic                  divide_by_zero;

  int  fail_count;
  int  pending;
  int  checked;
  int  tx_idle_pct  = 18;
  int  rx_idle_pct  = 18;
  bit  hold_off_req = 1'b0;
  int  idle_cycles  = 0;
  int  items_sent   = 0;
  int  zero_div_sent = 0;
  int  saturate_sent = 0;

  always #6 clk_i = ~clk_i;

  signed_integer_divider_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .dividend_i      (dividend),
    .divisor_i       (divisor),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .quotient_o      (quotient),
    .overflow_o      (overflow),
    .divide_by_zero_o(divide_by_zero)
  );

  sidv_div_checker #(
    .DATA_WIDTH(DATA_WIDTH)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .dividend_i      (dividend),
    .divisor_i       (divisor),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .quotient_i      (quotient),
    .overflow_i      (overflow),
    .divide_by_zero_i(divide_by_zero),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  // Offers one operand pair, after a random gap, and returns once it is taken.
  task automatic send_item(input logic [DATA_WIDTH-1:0] num, input logic [DATA_WIDTH-1:0] den);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    dividend <= num;
    divisor  <= den;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
    if (den == '0) zero_div_sent++;
    if (num == INT_MIN && den == '1) saturate_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Random magnitude of random bit length, so quotients of every size show up.
  function automatic logic [DATA_WIDTH-1:0] scaled_operand();
    logic [DATA_WIDTH-1:0] v;
    v = $urandom >> $urandom_range(DATA_WIDTH - 1);
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_dividend();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) begin
      case ($urandom_range(4))
        0:       return '0;
        1:       return INT_MIN;
        2:       return INT_MAX;
        3:       return '1;
        default: return INT_MIN + 1;
      endcase
    end else if (sel < 6) begin
      return scaled_operand();
    end
    return $urandom;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_divisor();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return '0;
    if (sel == 1) return $urandom_range(1) ? '1 : 1;
    if (sel < 7) return $urandom_range(1) ? -$urandom_range(16, 1) : $urandom_range(16, 1);
    if (sel < 13) return scaled_operand();
    return $urandom;
  endfunction

  // Receiver: random backpressure, plus a long hold-off when the sender asks.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("No item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Signs, extremes, zero divisors and the one overflowing pair.
    send_item(0, 1);
    send_item(0, -1);
    send_item(0, 0);
    send_item(5, 0);
    send_item(INT_MIN, 0);
    send_item(-1, 0);
    send_item(INT_MIN, -1);
    send_item(INT_MIN, 1);
    send_item(INT_MIN, INT_MIN);
    send_item(INT_MAX, INT_MIN);
    send_item(INT_MAX, 1);
    send_item(INT_MAX, -1);
    send_item(INT_MAX, INT_MAX);
    send_item(-7, 2);
    send_item(7, -2);
    send_item(-7, -2);
    send_item(7, 2);
    send_item(1, INT_MAX);
    send_item(INT_MIN, 2);
    send_item(INT_MIN, INT_MAX);
    send_item(-1, INT_MIN);
    send_item(100, 7);
    send_item(-100, 7);
    send_item(1, -1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 100) begin
        // Keep offering while the output is held off so the pipeline fills.
        tx_idle_pct  = 0;
        hold_off_req = 1'b1;
      end
      if (i == 140) tx_idle_pct = 18;
      if (i == 200) drain_results();
      if (i == 250) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (i == 350) begin
        tx_idle_pct = 18;
        rx_idle_pct = 18;
      end
      send_item(pick_dividend(), pick_divisor());
    end

    drain_results();
    repeat (LATENCY + 8) @(posedge clk_i);

    $display("Sent %0d operand pairs (%0d with zero divisor, %0d saturating), checked %0d.",
             items_sent, zero_div_sent, saturate_sent, checked);
    $display("Run included a %0d-cycle output hold-off and a full drain pause.",
             HOLD_OFF_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
